// ----- src/wsd_pkg.sv -----
// Shared constants and types of the WebSocket frame deframer.
// Used by the front parser, the job queue and the output stage.
package wsd_pkg;

    localparam int LENGTH_WIDTH = 64;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4095;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_PAYLOAD,
        OP_EMPTY,
        OP_ERROR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qpush;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ----- src/wsd_if.sv -----
// Valid/ready channel interfaces of the deframer: the raw byte stream and the results.
// Standalone; carries plain logic signals only.
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       empty_frame;
    logic       length_error;

    modport source (output valid, output payload_byte, output frame_end,
                    output empty_frame, output length_error, input ready);
    modport sink (input valid, input payload_byte, input frame_end,
                  input empty_frame, input length_error, output ready);
endinterface

// ----- src/wsd_front.sv -----
// Front parser: accepts stream bytes, tracks the frame header and classifies each byte.
// Depends on wsd_pkg and wsd_byte_if; pushes result jobs into wsd_queue.
module wsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_max_payload,
    wsd_byte_if.sink        i_in,
    input  wsd_pkg::t_qstat i_qstat,
    output wsd_pkg::t_qpush o_push
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_EXT,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    t_phase                    r_phase, n_phase;
    logic [3:0]                r_ext_left, n_ext_left;
    logic [LENGTH_WIDTH-1:0]   r_frame_len, n_frame_len;
    logic [31:0]               r_mask_key, n_mask_key;
    logic [LENGTH_WIDTH-1:0]   r_remaining, n_remaining;
    logic [1:0]                r_mask_pos, n_mask_pos;

    logic                      accept;
    logic [6:0]                len7;
    logic [7:0]                key_byte;
    logic [63:0]               len_ext;
    logic                      over;
    logic [LENGTH_WIDTH-1:0]   rem_dec;
    logic                      last;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign len7       = i_in.in_byte[6:0];
    assign len_ext    = 64'(r_frame_len);
    assign over       = (|len_ext[63:32]) || (len_ext[31:0] > i_max_payload);
    assign rem_dec    = r_remaining - LENGTH_WIDTH'(1);
    assign last       = (rem_dec == '0);

    always_comb begin
        case (r_mask_pos)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_ext_left  = r_ext_left;
        n_frame_len = r_frame_len;
        n_mask_key  = r_mask_key;
        n_remaining = r_remaining;
        n_mask_pos  = r_mask_pos;
        o_push      = '0;
        o_push.job.data = i_in.in_byte;
        o_push.job.key  = key_byte;
        o_push.job.last = last;
        if (accept) begin
            unique case (r_phase)
                PH_LENGTH: begin
                    n_mask_pos = 2'd0;
                    if (len7 == LEN7_EXT16) begin
                        n_frame_len = '0;
                        n_ext_left  = EXT16_BYTES;
                        n_phase     = PH_EXT;
                    end else if (len7 == LEN7_EXT64) begin
                        n_frame_len = '0;
                        n_ext_left  = EXT64_BYTES;
                        n_phase     = PH_EXT;
                    end else begin
                        n_frame_len = LENGTH_WIDTH'(len7);
                        n_phase     = PH_MASK;
                    end
                end
                PH_EXT: begin
                    n_frame_len = {r_frame_len[LENGTH_WIDTH-9:0], i_in.in_byte};
                    n_ext_left  = r_ext_left - 4'd1;
                    if (n_ext_left == 4'd0) begin
                        n_mask_pos = 2'd0;
                        n_phase    = PH_MASK;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_in.in_byte};
                    n_mask_pos = r_mask_pos + 2'd1;
                    if (n_mask_pos == 2'd0) begin
                        if (r_frame_len == '0) begin
                            o_push.valid  = 1'b1;
                            o_push.job.op = OP_EMPTY;
                            n_phase       = PH_HEADER;
                        end else begin
                            n_remaining = r_frame_len;
                            n_phase     = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_mask_pos  = r_mask_pos + 2'd1;
                    n_remaining = rem_dec;
                    if (last) begin
                        n_phase = PH_HEADER;
                    end
                    if (over) begin
                        o_push.valid  = last;
                        o_push.job.op = OP_ERROR;
                    end else begin
                        o_push.valid  = 1'b1;
                        o_push.job.op = OP_PAYLOAD;
                    end
                end
                default: begin
                    n_phase = PH_LENGTH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_ext_left  <= '0;
            r_frame_len <= '0;
            r_mask_key  <= '0;
            r_remaining <= '0;
            r_mask_pos  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_ext_left  <= n_ext_left;
            r_frame_len <= n_frame_len;
            r_mask_key  <= n_mask_key;
            r_remaining <= n_remaining;
            r_mask_pos  <= n_mask_pos;
        end
    end

endmodule

// ----- src/wsd_queue.sv -----
// Short job queue that decouples the front parser from the output stage.
// Depends on wsd_pkg for the job and status types.
module wsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wsd_pkg::t_qpush i_push,
    input  logic            i_pop,
    output wsd_pkg::t_job   o_head,
    output wsd_pkg::t_qstat o_stat
);
    import wsd_pkg::*;

    t_job                r_slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head       = r_slots[r_rd_ptr];
    assign do_push      = i_push.valid && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_push.job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/wsd_back.sv -----
// Output stage: takes jobs from the queue, unmasks payload bytes and holds the result register.
// Depends on wsd_pkg and wsd_result_if.
module wsd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wsd_pkg::t_job   i_head,
    input  wsd_pkg::t_qstat i_qstat,
    output logic            o_pop,
    wsd_result_if.source    o_out
);
    import wsd_pkg::*;

    logic       r_valid;
    logic [7:0] r_payload_byte;
    logic       r_frame_end;
    logic       r_empty_frame;
    logic       r_length_error;

    assign o_pop = !i_qstat.empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_payload_byte <= (i_head.op == OP_PAYLOAD) ? (i_head.data ^ i_head.key) : 8'd0;
            r_frame_end    <= (i_head.op != OP_PAYLOAD) || i_head.last;
            r_empty_frame  <= (i_head.op == OP_EMPTY);
            r_length_error <= (i_head.op == OP_ERROR);
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.payload_byte = r_payload_byte;
    assign o_out.frame_end    = r_frame_end;
    assign o_out.empty_frame  = r_empty_frame;
    assign o_out.length_error = r_length_error;

endmodule

// ----- src/websocket_frame_deframer.sv -----
// Top level of the WebSocket client frame deframer with payload unmasking.
// Depends on wsd_pkg, wsd_if, wsd_front, wsd_queue and wsd_back.
//
// The input channel carries one raw stream byte per transfer; the output channel
// carries one result per transfer: an unmasked payload byte, an empty-frame marker
// or an oversize marker, with frame_end set on the last result of each frame.
// Header, length and mask bytes produce no result.
// The maximum payload register is written through i_cfg_wr_en and i_cfg_wr_data.
// A transferred byte is written into the job queue as a job and is offered as a
// result once the output stage has popped it into its output register.
// One byte is accepted every cycle while the four-entry job queue has room.
// The queue and the output register let the parser keep taking bytes while
// the receiver stalls; input ready drops only once the queue is full.
// Synchronous reset returns the parser to the first header byte, empties the
// queue and output register, and restores the maximum payload to 4095.
module websocket_frame_deframer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,
    wsd_byte_if.sink     i_in,
    wsd_result_if.source o_out
);
    import wsd_pkg::*;

    logic [31:0] r_max_payload;
    t_qpush      push;
    t_qstat      qstat;
    t_job        head;
    logic        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_payload <= i_cfg_wr_data;
        end
    end

    wsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_payload (r_max_payload),
        .i_in          (i_in),
        .i_qstat       (qstat),
        .o_push        (push)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    wsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_no_result_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out.valid)
        else $error("result presented straight after reset");

    a_error_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.length_error |->
            o_out.frame_end && !o_out.empty_frame && (o_out.payload_byte == 8'd0))
        else $error("malformed oversize result");

    a_empty_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.empty_frame |->
            o_out.frame_end && !o_out.length_error && (o_out.payload_byte == 8'd0))
        else $error("malformed empty-frame result");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.full |-> !i_in.ready)
        else $error("input ready while the job queue is full");

    a_pop_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_out.valid)
        else $error("queue pop did not load the output register");

endmodule

// ----- tb/websocket_frame_deframer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer: streams client frames byte by byte
// and checks every unmasked byte, empty-frame and oversize marker against its own parser.
// Depends on wsd_pkg, wsd_if and the deframer RTL.
module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_EXT,
        PH_MASK,
        PH_PAYLOAD
    } t_parse_phase;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } t_len_form;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       empty;
        logic       oversize;
    } t_ws_result;

    class frame_unmask_tracker;
        t_ws_result   expected_q[$];
        int unsigned  mismatches;
        int unsigned  checked;
        int unsigned  empties;
        int unsigned  oversized;
        int unsigned  bytes_in;
        logic [31:0]  max_payload;
        t_parse_phase phase;
        logic [3:0]   ext_left;
        logic [63:0]  frame_len;
        logic [63:0]  bytes_left;
        logic [31:0]  mask_key;
        logic [1:0]   mask_pos;

        function new();
            mismatches  = 0;
            checked     = 0;
            empties     = 0;
            oversized   = 0;
            bytes_in    = 0;
            max_payload = MAX_PAYLOAD_RESET;
            phase       = PH_HEADER;
            ext_left    = '0;
            frame_len   = '0;
            bytes_left  = '0;
            mask_key    = '0;
            mask_pos    = '0;
        endfunction

        function void push_result(logic [7:0] data, logic last, logic empty, logic oversize);
            t_ws_result r;
            r.data     = data;
            r.last     = last;
            r.empty    = empty;
            r.oversize = oversize;
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [63:0] len_mask;
            logic        over;
            logic [7:0]  key;
            len_mask = (LENGTH_WIDTH >= 64) ? '1 : ((64'd1 << LENGTH_WIDTH) - 64'd1);
            bytes_in++;
            case (phase)
                PH_LENGTH: begin
                    mask_pos = '0;
                    if (b[6:0] == LEN7_EXT16) begin
                        frame_len = '0;
                        ext_left  = EXT16_BYTES;
                        phase     = PH_EXT;
                    end else if (b[6:0] == LEN7_EXT64) begin
                        frame_len = '0;
                        ext_left  = EXT64_BYTES;
                        phase     = PH_EXT;
                    end else begin
                        frame_len = 64'(b[6:0]);
                        phase     = PH_MASK;
                    end
                end
                PH_EXT: begin
                    frame_len = ((frame_len << 8) | 64'(b)) & len_mask;
                    ext_left  = ext_left - 4'd1;
                    if (ext_left == '0) begin
                        mask_pos = '0;
                        phase    = PH_MASK;
                    end
                end
                PH_MASK: begin
                    mask_key = {mask_key[23:0], b};
                    mask_pos = mask_pos + 2'd1;
                    if (mask_pos == '0) begin
                        if (frame_len == '0) begin
                            phase = PH_HEADER;
                            push_result(8'h00, 1'b1, 1'b1, 1'b0);
                        end else begin
                            bytes_left = frame_len;
                            phase      = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    over       = frame_len > 64'(max_payload);
                    key        = 8'(mask_key >> (8 * (3 - int'(mask_pos))));
                    mask_pos   = mask_pos + 2'd1;
                    bytes_left = bytes_left - 64'd1;
                    if (bytes_left == '0)
                        phase = PH_HEADER;
                    if (over) begin
                        if (bytes_left == '0)
                            push_result(8'h00, 1'b1, 1'b0, 1'b1);
                    end else begin
                        push_result(b ^ key, bytes_left == '0, 1'b0, 1'b0);
                    end
                end
                PH_HEADER: phase = PH_LENGTH;
                default:   phase = PH_LENGTH;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [7:0] data, logic last, logic empty, logic oversize);
            t_ws_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: unexpected result, expected none, actual %0h/%b/%b/%b",
                             $time, data, last, empty, oversize);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.empty)
                empties++;
            if (want.oversize)
                oversized++;
            compare_field("payload_byte", want.data, data);
            compare_field("frame_end", 8'(want.last), 8'(last));
            compare_field("empty_frame", 8'(want.empty), 8'(empty));
            compare_field("length_error", 8'(want.oversize), 8'(oversize));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        tx_idle_on = 1'b1;
    logic        rx_stall_on = 1'b1;
    int unsigned hold_requests = 0;

    frame_unmask_tracker tracker = new();

    wsd_byte_if   byte_ch ();
    wsd_result_if result_ch ();

    websocket_frame_deframer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (byte_ch),
        .o_out         (result_ch)
    );

    always #5 clk = ~clk;

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : result_sink
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left    = 0;
        holds_served = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = 64;
            end
            if (hold_left != 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (rx_stall_on) begin
                result_ch.ready <= ($urandom_range(99) >= 30);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Handshake signals are sampled on the falling edge, clear of the rising edge
    // at which the transfer completes.
    always @(negedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.check_result(result_ch.payload_byte, result_ch.frame_end,
                                 result_ch.empty_frame, result_ch.length_error);
    end

    task automatic send_byte(input logic [7:0] b);
        logic fire;
        while (tx_idle_on && $urandom_range(99) < 30) begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do begin
            @(negedge clk);
            fire = byte_ch.ready;
            @(posedge clk);
        end while (!fire);
        tracker.note_byte(b);
    endtask

    task automatic send_frame(input logic [63:0] len, input t_len_form form,
                              input int unsigned body_len, input logic [31:0] key);
        logic mbit;
        mbit = 1'($urandom_range(1));
        send_byte(8'($urandom));
        case (form)
            FORM_EXT16: begin
                send_byte({mbit, LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            FORM_EXT64: begin
                send_byte({mbit, LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            default: begin
                send_byte({mbit, len[6:0]});
            end
        endcase
        for (int i = 3; i >= 0; i--)
            send_byte(key[8*i +: 8]);
        repeat (body_len) send_byte(8'($urandom));
    endtask

    task automatic send_random_frame(input int unsigned max_len);
        int unsigned len;
        int unsigned pick;
        t_len_form   form;
        pick = $urandom_range(99);
        if (pick < 15)
            len = 0;
        else if (pick < 25)
            len = max_len;
        else
            len = $urandom_range(max_len, 1);
        pick = $urandom_range(99);
        if (len > 125)
            form = (pick < 50) ? FORM_EXT16 : FORM_EXT64;
        else if (pick < 60)
            form = FORM_SHORT;
        else if (pick < 80)
            form = FORM_EXT16;
        else
            form = FORM_EXT64;
        send_frame(64'(len), form, len, $urandom);
    endtask

    task automatic run_frames(input int unsigned byte_budget, input int unsigned max_len);
        int unsigned start;
        start = tracker.bytes_in;
        while (tracker.bytes_in - start < byte_budget)
            send_random_frame(max_len);
    endtask

    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_payload(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.max_payload = value;
    endtask

    initial begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(64'd0, FORM_SHORT, 0, 32'h0000_0000);
        send_frame(64'd1, FORM_SHORT, 1, 32'hFFFF_FFFF);
        send_frame(64'd2, FORM_EXT16, 2, $urandom);
        send_frame(64'd1, FORM_EXT64, 1, $urandom);
        send_frame(64'd125, FORM_SHORT, 125, $urandom);
        run_frames(10, 30);
        settle();

        write_max_payload(32'd0);
        send_frame(64'd0, FORM_EXT64, 0, $urandom);
        run_frames(10, 12);
        settle();

        write_max_payload(32'd16);
        send_frame(64'd16, FORM_SHORT, 16, $urandom);
        send_frame(64'd17, FORM_EXT16, 17, $urandom);
        settle();

        write_max_payload(32'hFFFF_FFFF);
        tx_idle_on = 1'b0;
        rx_stall_on <= 1'b0;
        hold_requests <= hold_requests + 1;
        send_frame(64'd24, FORM_SHORT, 24, $urandom);
        run_frames(20, 30);
        tx_idle_on = 1'b1;
        rx_stall_on <= 1'b1;
        run_frames(20, 60);
        settle();

        write_max_payload(32'd20);
        send_frame(64'd20, FORM_SHORT, 20, $urandom);
        send_frame(64'd21, FORM_EXT64, 21, $urandom);
        run_frames(10, 24);
        // A frame of the largest possible length is left open at the end of the stream.
        send_frame('1, FORM_EXT64, 8, $urandom);
        settle();

        $display("Streamed %0d bytes under five payload limits, from zero to the 32-bit maximum.",
                 tracker.bytes_in);
        $display("Checked %0d results: %0d empty-frame and %0d oversize markers.",
                 tracker.checked, tracker.empties, tracker.oversized);
        if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
src/wsd_pkg.sv
src/wsd_if.sv
src/wsd_front.sv
src/wsd_queue.sv
src/wsd_back.sv
src/websocket_frame_deframer.sv
tb/websocket_frame_deframer_tb.sv
